/* rtl/core/v2dc_pkg.sv */
`default_nettype none
package v2dc_pkg;
  localparam int MAX_SIZE_D = 32;
  localparam int KERNEL_D = 5;
  localparam int PIXEL_BITS_D = 8;
  localparam int SIZE_W = 6;
  localparam int COEF_W = 40;
  localparam int NUM_REGS = 6;
  localparam int SUM_W = 21;
  localparam int IDX_W = 5;
  localparam int CFG_IDX_W = 3;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_SIZE = 3'd0,
    REG_ROW0 = 3'd1,
    REG_ROW1 = 3'd2,
    REG_ROW2 = 3'd3,
    REG_ROW3 = 3'd4,
    REG_ROW4 = 3'd5
  } reg_idx_t;

  typedef struct packed {
    logic       frame_start;
    logic [7:0] pixel;
  } in_req_t;

  typedef struct packed {
    logic             frame_last;
    logic [IDX_W-1:0] out_col;
    logic [IDX_W-1:0] out_row;
    logic [SUM_W-1:0] conv_sum;
  } out_req_t;
endpackage
`default_nettype wire

/* rtl/core/v2dc_ram.sv */
`default_nettype none
module v2dc_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 32
) (
  input  wire logic                     clk,
  input  wire logic                     we,
  input  wire logic [$clog2(DEPTH)-1:0] waddr,
  input  wire logic [WIDTH-1:0]         wdata,
  input  wire logic                     re,
  input  wire logic [$clog2(DEPTH)-1:0] raddr,
  output logic      [WIDTH-1:0]         rdata
);
  logic [WIDTH-1:0] mem [DEPTH];
  always_ff @(posedge clk) begin
    if (we) mem[waddr] <= wdata;
    if (re) rdata <= mem[raddr];
  end
endmodule
`default_nettype wire

/* rtl/core/v2dc_front.sv */
`default_nettype none
// Position counters, line store and window; emits classified windows to the queue.
module v2dc_front #(
  parameter int MAX_SIZE   = v2dc_pkg::MAX_SIZE_D,
  parameter int KERNEL     = v2dc_pkg::KERNEL_D,
  parameter int PIXEL_BITS = v2dc_pkg::PIXEL_BITS_D
) (
  input  wire logic                                clk,
  input  wire logic                                rst_n,
  input  wire logic [v2dc_pkg::SIZE_W-1:0]         side,
  input  wire logic                                in_valid,
  output logic                                     in_stall,
  input  wire v2dc_pkg::in_req_t                   in_req,
  input  wire logic                                q_full,
  output logic                                     q_push,
  output logic [KERNEL*KERNEL*PIXEL_BITS-1:0]      q_win,
  output logic [v2dc_pkg::IDX_W-1:0]               q_row,
  output logic [v2dc_pkg::IDX_W-1:0]               q_col,
  output logic                                     q_last
);
  localparam int CW = $clog2(MAX_SIZE + 1);
  localparam int AW = $clog2(MAX_SIZE);
  localparam int HW = (KERNEL - 1) * PIXEL_BITS;

  logic [CW-1:0] row_r, col_r;
  logic [CW-1:0] row_c, col_c, row_nxt, col_nxt;
  logic [CW-1:0] side_c;
  logic          acc;
  // stage 1: accepted pixel awaiting line store read
  logic          s1_v_r, s1_out_r, s1_last_r;
  logic [PIXEL_BITS-1:0] s1_pix_r;
  logic [CW-1:0] s1_row_r, s1_col_r;
  logic [HW-1:0] hist;
  logic [HW-1:0] hist_e, lw_data, byp_data_r;
  logic          byp_r;
  logic [PIXEL_BITS-1:0] win_r [KERNEL][KERNEL];
  logic [PIXEL_BITS-1:0] colv [KERNEL];

  assign side_c = CW'(side);
  assign in_stall = q_full;
  assign acc = in_valid && !in_stall;

  always_comb begin
    row_c = row_r;
    col_c = col_r;
    if (in_req.frame_start) begin
      row_c = '0;
      col_c = '0;
    end
    if (col_c >= side_c) begin
      col_c = '0;
      row_c = row_c + 1'b1;
    end
    if (row_c >= side_c) row_c = '0;
    col_nxt = col_c + 1'b1;
    row_nxt = row_c;
    if (col_nxt >= side_c) begin
      col_nxt = '0;
      row_nxt = row_c + 1'b1;
      if (row_nxt >= side_c) row_nxt = '0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      row_r  <= '0;
      col_r  <= '0;
      s1_v_r <= 1'b0;
      byp_r  <= 1'b0;
    end else begin
      s1_v_r <= acc;
      byp_r  <= acc && s1_v_r && (s1_col_r == col_c);
      if (acc) begin
        row_r <= row_nxt;
        col_r <= col_nxt;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (acc) begin
      s1_pix_r  <= in_req.pixel[PIXEL_BITS-1:0];
      s1_row_r  <= row_c;
      s1_col_r  <= col_c;
      s1_out_r  <= (row_c >= CW'(KERNEL - 1)) && (col_c >= CW'(KERNEL - 1));
      s1_last_r <= (row_c == side_c - 1'b1) && (col_c == side_c - 1'b1);
    end
  end

  // same column back to back (repeated frame start) takes the word being written
  always_ff @(posedge clk) begin
    byp_data_r <= lw_data;
  end

  assign hist_e  = byp_r ? byp_data_r : hist;
  assign lw_data = HW'({hist_e, s1_pix_r});

  // one wide entry per column holds the KERNEL-1 previous rows, newest lowest
  v2dc_ram #(.WIDTH(HW), .DEPTH(MAX_SIZE)) u_lines (
    .clk   (clk),
    .we    (s1_v_r),
    .waddr (s1_col_r[AW-1:0]),
    .wdata (lw_data),
    .re    (acc),
    .raddr (col_c[AW-1:0]),
    .rdata (hist)
  );

  always_comb begin
    for (int a = 0; a < KERNEL - 1; a++)
      colv[a] = hist_e[(KERNEL-2-a)*PIXEL_BITS +: PIXEL_BITS];
    colv[KERNEL-1] = s1_pix_r;
  end

  always_ff @(posedge clk) begin
    if (s1_v_r) begin
      for (int a = 0; a < KERNEL; a++) begin
        for (int b = 0; b < KERNEL - 1; b++) win_r[a][b] <= win_r[a][b+1];
        win_r[a][KERNEL-1] <= colv[a];
      end
    end
  end

  // stage 2: window complete, push
  logic s2_v_r, s2_last_r;
  logic [CW-1:0] s2_row_r, s2_col_r;
  always_ff @(posedge clk) begin
    if (!rst_n) s2_v_r <= 1'b0;
    else        s2_v_r <= s1_v_r && s1_out_r;
  end
  always_ff @(posedge clk) begin
    s2_row_r  <= s1_row_r - CW'(KERNEL - 1);
    s2_col_r  <= s1_col_r - CW'(KERNEL - 1);
    s2_last_r <= s1_last_r;
  end

  assign q_push = s2_v_r;
  assign q_row  = v2dc_pkg::IDX_W'(s2_row_r);
  assign q_col  = v2dc_pkg::IDX_W'(s2_col_r);
  assign q_last = s2_last_r;
  always_comb begin
    for (int a = 0; a < KERNEL; a++)
      for (int b = 0; b < KERNEL; b++)
        q_win[(a*KERNEL+b)*PIXEL_BITS +: PIXEL_BITS] = win_r[a][b];
  end
endmodule
`default_nettype wire

/* rtl/core/v2dc_queue.sv */
`default_nettype none
module v2dc_queue #(
  parameter int WIDTH = 8
) (
  input  wire logic             clk,
  input  wire logic             rst_n,
  input  wire logic             push,
  input  wire logic [WIDTH-1:0] push_data,
  output logic                  almost_full,
  input  wire logic             pop,
  output logic                  not_empty,
  output logic [WIDTH-1:0]      pop_data
);
  // depth covers the two pushes in flight after stall rises
  localparam int DEPTH = 4;
  logic [WIDTH-1:0] mem_r [DEPTH];
  logic [1:0] wp_r, rp_r;
  logic [2:0] cnt_r;

  assign not_empty   = cnt_r != 3'd0;
  assign almost_full = cnt_r >= 3'd2;
  assign pop_data    = mem_r[rp_r];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wp_r  <= '0;
      rp_r  <= '0;
      cnt_r <= '0;
    end else begin
      if (push) wp_r <= wp_r + 1'b1;
      if (pop)  rp_r <= rp_r + 1'b1;
      cnt_r <= cnt_r + 3'(push) - 3'(pop);
    end
  end
  always_ff @(posedge clk) begin
    if (push) mem_r[wp_r] <= push_data;
  end

  assert property (@(posedge clk) disable iff (!rst_n) !(push && cnt_r == 3'd4 && !pop))
    else $error("queue overflow");
  assert property (@(posedge clk) disable iff (!rst_n) !(pop && cnt_r == 3'd0))
    else $error("queue underflow");
endmodule
`default_nettype wire

/* rtl/core/v2dc_back.sv */
`default_nettype none
// Two stage multiply-accumulate: row sums of products, then the total of the row sums.
module v2dc_back #(
  parameter int KERNEL     = v2dc_pkg::KERNEL_D,
  parameter int PIXEL_BITS = v2dc_pkg::PIXEL_BITS_D
) (
  input  wire logic                                clk,
  input  wire logic                                rst_n,
  input  wire logic [v2dc_pkg::COEF_W-1:0]         coef [KERNEL],
  input  wire logic                                q_ne,
  output logic                                     q_pop,
  input  wire logic [KERNEL*KERNEL*PIXEL_BITS-1:0] q_win,
  input  wire logic [v2dc_pkg::IDX_W-1:0]          q_row,
  input  wire logic [v2dc_pkg::IDX_W-1:0]          q_col,
  input  wire logic                                q_last,
  output logic                                     out_valid,
  input  wire logic                                out_stall,
  output v2dc_pkg::out_req_t                       out_req
);
  localparam int PW = PIXEL_BITS + 8;
  localparam int RW = PW + $clog2(KERNEL + 1);
  localparam int SW = v2dc_pkg::SUM_W;

  logic          p_v_r, o_v_r, adv_p, adv_o;
  logic [RW-1:0] rs_r [KERNEL];
  logic [v2dc_pkg::IDX_W-1:0] p_row_r, p_col_r;
  logic          p_last_r;
  logic [RW-1:0] rs_c [KERNEL];
  logic [SW+8-1:0] tot;

  assign adv_o = !o_v_r || !out_stall;
  assign adv_p = !p_v_r || adv_o;
  assign q_pop = q_ne && adv_p;

  always_comb begin
    for (int a = 0; a < KERNEL; a++) begin
      rs_c[a] = '0;
      for (int b = 0; b < KERNEL; b++)
        rs_c[a] = rs_c[a] + RW'(q_win[(a*KERNEL+b)*PIXEL_BITS +: PIXEL_BITS]
                               * coef[a][b*8 +: 8]);
    end
    tot = '0;
    for (int a = 0; a < KERNEL; a++) tot = tot + (SW+8)'(rs_r[a]);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      p_v_r <= 1'b0;
      o_v_r <= 1'b0;
    end else begin
      if (adv_p) p_v_r <= q_ne;
      if (adv_o) o_v_r <= p_v_r;
    end
  end
  always_ff @(posedge clk) begin
    if (q_pop) begin
      rs_r     <= rs_c;
      p_row_r  <= q_row;
      p_col_r  <= q_col;
      p_last_r <= q_last;
    end
    if (adv_o && p_v_r) begin
      out_req.conv_sum   <= tot[SW-1:0];
      out_req.out_row    <= p_row_r;
      out_req.out_col    <= p_col_r;
      out_req.frame_last <= p_last_r;
    end
  end
  assign out_valid = o_v_r;

  assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_stall |=> out_valid && $stable(out_req))
    else $error("result changed under stall");
endmodule
`default_nettype wire

/* rtl/core/valid_2d_convolution.sv */
`default_nettype none
// An accepted pixel passes stage 1, stage 2, the queue, then the row and total MAC stages.
// Throughput: one pixel per cycle while in_stall is low; the line store is one
// dual-port RAM read ahead of the window shift, the MAC is split into row and total stages.
// Reset (rst_n low, synchronous): counters and handshake state clear, image_size
// returns to 32 and coefficients to zero; line store contents stay undefined.
module valid_2d_convolution #(
  parameter int MAX_SIZE   = v2dc_pkg::MAX_SIZE_D,
  parameter int KERNEL     = v2dc_pkg::KERNEL_D,
  parameter int PIXEL_BITS = v2dc_pkg::PIXEL_BITS_D
) (
  input  wire logic                               clk,
  input  wire logic                               rst_n,
  input  wire logic                               in_valid,
  output logic                                    in_stall,
  input  wire v2dc_pkg::in_req_t                  in_req,
  output logic                                    out_valid,
  input  wire logic                               out_stall,
  output v2dc_pkg::out_req_t                      out_req,
  input  wire logic                               cfg_valid,
  output logic                                    cfg_ready,
  input  wire logic [v2dc_pkg::CFG_IDX_W-1:0]     cfg_index,
  input  wire logic [v2dc_pkg::COEF_W-1:0]        cfg_data
);
  localparam int WW = KERNEL * KERNEL * PIXEL_BITS;
  localparam int QW = WW + 2 * v2dc_pkg::IDX_W + 1;
  localparam int CW = $clog2(MAX_SIZE + 1);

  logic [v2dc_pkg::SIZE_W-1:0] size_r, side;
  logic [v2dc_pkg::COEF_W-1:0] coef_r [KERNEL];
  logic [v2dc_pkg::COEF_W-1:0] coef_all_r [5];

  assign cfg_ready = 1'b1;
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      size_r <= v2dc_pkg::SIZE_W'(32);
      for (int i = 0; i < 5; i++) coef_all_r[i] <= '0;
    end else if (cfg_valid) begin
      unique case (v2dc_pkg::reg_idx_t'(cfg_index))
        v2dc_pkg::REG_SIZE: size_r <= cfg_data[v2dc_pkg::SIZE_W-1:0];
        v2dc_pkg::REG_ROW0: coef_all_r[0] <= cfg_data;
        v2dc_pkg::REG_ROW1: coef_all_r[1] <= cfg_data;
        v2dc_pkg::REG_ROW2: coef_all_r[2] <= cfg_data;
        v2dc_pkg::REG_ROW3: coef_all_r[3] <= cfg_data;
        v2dc_pkg::REG_ROW4: coef_all_r[4] <= cfg_data;
        default: ;
      endcase
    end
  end
  always_comb begin
    for (int i = 0; i < KERNEL; i++) coef_r[i] = coef_all_r[i];
    if (32'(size_r) < KERNEL)        side = v2dc_pkg::SIZE_W'(KERNEL);
    else if (32'(size_r) > MAX_SIZE) side = v2dc_pkg::SIZE_W'(MAX_SIZE);
    else                             side = size_r;
  end

  logic q_push, q_af, q_pop, q_ne, f_last, b_last;
  logic [WW-1:0] f_win, b_win;
  logic [v2dc_pkg::IDX_W-1:0] f_row, f_col, b_row, b_col;

  v2dc_front #(.MAX_SIZE(MAX_SIZE), .KERNEL(KERNEL), .PIXEL_BITS(PIXEL_BITS)) u_front (
    .clk(clk), .rst_n(rst_n), .side(side),
    .in_valid(in_valid), .in_stall(in_stall), .in_req(in_req),
    .q_full(q_af), .q_push(q_push), .q_win(f_win),
    .q_row(f_row), .q_col(f_col), .q_last(f_last)
  );

  v2dc_queue #(.WIDTH(QW)) u_queue (
    .clk(clk), .rst_n(rst_n),
    .push(q_push), .push_data({f_last, f_col, f_row, f_win}),
    .almost_full(q_af),
    .pop(q_pop), .not_empty(q_ne), .pop_data({b_last, b_col, b_row, b_win})
  );

  v2dc_back #(.KERNEL(KERNEL), .PIXEL_BITS(PIXEL_BITS)) u_back (
    .clk(clk), .rst_n(rst_n), .coef(coef_r),
    .q_ne(q_ne), .q_pop(q_pop), .q_win(b_win),
    .q_row(b_row), .q_col(b_col), .q_last(b_last),
    .out_valid(out_valid), .out_stall(out_stall), .out_req(out_req)
  );

  assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_req.frame_last |-> out_req.out_row == out_req.out_col)
    else $error("frame_last off the diagonal");
  assert property (@(posedge clk) disable iff (!rst_n)
    32'(side) >= KERNEL && 32'(side) <= MAX_SIZE && CW > 0)
    else $error("side out of range");
endmodule
`default_nettype wire
